@@ rtl/core/imh_pkg.sv @@
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants of the indexed min-heap
// Sizes, operation and status codes, position table request and response types.
// ----------------------------------------------------------------------------
`default_nettype none
package imh_pkg;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned SlotW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned IdW      = 10;
  localparam int unsigned IdCount  = 1 << IdW;
  localparam int unsigned PriW     = 32;
  localparam int unsigned EntryW   = IdW + PriW;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_DECR    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DUP   = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [PriW-1:0] pri;
  } entry_t;

  // position table access from the controller
  typedef struct packed {
    logic             we;
    logic [IdW-1:0]   waddr;
    logic             wvalid;
    logic [SlotW-1:0] wslot;
    logic [IdW-1:0]   raddr;
  } pos_req_t;

  typedef struct packed {
    logic             valid;
    logic [SlotW-1:0] slot;
  } pos_rsp_t;
endpackage
`default_nettype wire

@@ rtl/core/imh_pos_table.sv @@
// ----------------------------------------------------------------------------
// imh_pos_table: id to heap slot map
// Synchronous RAM of present bit and slot per id, marked absent by a clearing
// pass over all ids after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module imh_pos_table (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  imh_pkg::pos_req_t  req_i,
  output imh_pkg::pos_rsp_t  rsp_o,
  output logic               busy_o
);
  // entry: [SlotW] present, [SlotW-1:0] slot
  logic [imh_pkg::SlotW:0] mem [imh_pkg::IdCount];
  logic [imh_pkg::SlotW:0] rdata_q;
  logic [imh_pkg::IdW-1:0] clr_q;
  logic                    clr_busy_q;
  logic                    we;
  logic [imh_pkg::IdW-1:0] waddr;
  logic [imh_pkg::SlotW:0] wdata;

  // walk every id once after reset and mark it absent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign we    = clr_busy_q || req_i.we;
  assign waddr = clr_busy_q ? clr_q : req_i.waddr;
  assign wdata = clr_busy_q ? '0 : {req_i.wvalid, req_i.wslot};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rsp_o.valid = rdata_q[imh_pkg::SlotW];
  assign rsp_o.slot  = rdata_q[imh_pkg::SlotW-1:0];
  assign busy_o      = clr_busy_q;
endmodule
`default_nettype wire

@@ rtl/core/imh_heap_ram.sv @@
// ----------------------------------------------------------------------------
// imh_heap_ram: heap slot store
// One write port, one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module imh_heap_ram (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [imh_pkg::SlotW-1:0] waddr_i,
  input  imh_pkg::entry_t           wdata_i,
  input  wire  [imh_pkg::SlotW-1:0] raddr_i,
  output imh_pkg::entry_t           rdata_o
);
  imh_pkg::entry_t mem [imh_pkg::Capacity];
  imh_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

@@ rtl/core/indexed_min_heap_decrease_key.sv @@
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key: indexed binary min-heap with decrease key
// Sequencer over a heap slot RAM and an id position table.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transfer: insert, extract minimum or
//   decrease key. m_axis returns exactly one result per operation with the
//   extracted element, applied flag, status, empty flag and element count.
//   One operation at a time. An empty extract, the unused opcode and a full
//   or duplicate insert return without touching the heap. An insert
//   compares with up to 10 ancestors, a decrease with up to 10 ancestors of
//   its slot, and an extract sinks the last node through up to 9 levels.
//   Sift down reads both children, where there are two, on the single read
//   port, one per cycle. The moving node is held in a register and written
//   once at its final slot; displaced nodes are written as they move, each
//   with its position. Reset empties the heap and starts a clearing pass
//   that marks all 1024 ids absent, with s_axis_tready held low until the
//   pass ends. A stalled result is held in the output register, and the
//   next operation is taken only once it has gone.
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_min_heap_decrease_key (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] opcode, [11:2] elem_id, [43:12] priority_req, [47:44] zero
  input  wire  [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [9:0] out_elem, [41:10] out_priority, [42] applied, [44:43] status,
  // [45] heap_empty, [56:46] count, [63:57] zero
  output logic [63:0] m_axis_tdata
);
  localparam int unsigned SlotW  = imh_pkg::SlotW;
  localparam int unsigned CountW = imh_pkg::CountW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POS   = 4'd1;  // position read returns
  localparam logic [3:0] S_ROOT  = 4'd2;  // root / decreased slot read returns
  localparam logic [3:0] S_LAST  = 4'd3;  // last slot read returns
  localparam logic [3:0] S_UPRD  = 4'd4;  // parent read returns
  localparam logic [3:0] S_DNL   = 4'd5;  // left child returns
  localparam logic [3:0] S_DNR   = 4'd6;  // right child returns
  localparam logic [3:0] S_FIN   = 4'd7;  // write moving node
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] op_q, op_d;
  imh_pkg::entry_t mv_q, mv_d;        // node being sifted
  imh_pkg::entry_t lc_q, lc_d;        // left child held during sift down
  logic [SlotW-1:0] pos_q, pos_d;     // current slot of moving node
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [63:0] out_q, out_d;
  logic out_v_q, out_v_d;

  logic             hw_we;
  logic [SlotW-1:0] hw_addr, hr_addr;
  imh_pkg::entry_t  hw_data, hr_data;
  imh_pkg::pos_req_t preq;
  imh_pkg::pos_rsp_t prsp;
  logic             pos_busy;

  imh_heap_ram u_heap (
    .clk_i  (clk_i),
    .we_i   (hw_we),
    .waddr_i(hw_addr),
    .wdata_i(hw_data),
    .raddr_i(hr_addr),
    .rdata_o(hr_data)
  );

  imh_pos_table u_pos (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (preq),
    .rsp_o (prsp),
    .busy_o(pos_busy)
  );

  wire s_fire = s_axis_tvalid && s_axis_tready;
  wire [1:0] in_op = s_axis_tdata[1:0];
  wire [imh_pkg::IdW-1:0] in_id = s_axis_tdata[11:2];
  wire [imh_pkg::PriW-1:0] in_pri = s_axis_tdata[43:12];

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q && !pos_busy;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  function automatic logic pri_lt(input logic [31:0] a, input logic [31:0] b);
    pri_lt = $signed(a) < $signed(b);
  endfunction

  function automatic logic [63:0] pack_out(input logic [9:0] e, input logic [31:0] p,
                                           input logic ap, input logic [1:0] st,
                                           input logic [CountW-1:0] c);
    pack_out = {7'd0, c, (c == '0), st, ap, p, e};
  endfunction

  logic [SlotW-1:0] parent, lchild;
  logic [SlotW:0] lchild_w;
  logic full;
  assign parent   = (pos_q - 1'b1) >> 1;
  assign lchild_w = {pos_q, 1'b1};
  assign lchild   = lchild_w[SlotW-1:0];
  assign full     = (cnt_q >= CountW'(imh_pkg::Capacity));

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    mv_d    = mv_q;
    lc_d    = lc_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    out_d   = out_q;
    out_v_d = out_v_q;
    hw_we   = 1'b0;
    hw_addr = pos_q;
    hw_data = mv_q;
    hr_addr = '0;
    preq    = '0;

    if (out_v_q && m_axis_tready) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          op_d      = in_op;
          mv_d.id   = in_id;
          mv_d.pri  = in_pri;
          preq.raddr = in_id;
          hr_addr   = '0;
          unique case (in_op)
            imh_pkg::OP_INSERT, imh_pkg::OP_DECR: state_d = S_POS;
            imh_pkg::OP_EXTRACT: begin
              if (cnt_q == '0) begin
                out_d = pack_out('0, '0, 1'b0, imh_pkg::ST_EMPTY, cnt_q);
                out_v_d = 1'b1;
              end else begin
                state_d = S_ROOT;
              end
            end
            default: begin
              out_d = pack_out('0, '0, 1'b0, imh_pkg::ST_OK, cnt_q);
              out_v_d = 1'b1;
            end
          endcase
        end
      end
      S_POS: begin
        if (op_q == imh_pkg::OP_INSERT) begin
          if (full) begin
            out_d = pack_out('0, '0, 1'b0, imh_pkg::ST_FULL, cnt_q);
            state_d = S_OUT;
          end else if (prsp.valid) begin
            out_d = pack_out('0, '0, 1'b0, imh_pkg::ST_DUP, cnt_q);
            state_d = S_OUT;
          end else begin
            pos_d = cnt_q[SlotW-1:0];
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == '0) begin
              state_d = S_FIN;
            end else begin
              hr_addr = (cnt_q[SlotW-1:0] - 1'b1) >> 1;
              state_d = S_UPRD;
            end
          end
        end else begin
          // decrease key: fetch held priority
          if (prsp.valid && ({1'b0, prsp.slot} < cnt_q)) begin
            pos_d   = prsp.slot;
            hr_addr = prsp.slot;
            state_d = S_ROOT;
          end else begin
            out_d = pack_out('0, '0, 1'b0, imh_pkg::ST_OK, cnt_q);
            state_d = S_OUT;
          end
        end
      end
      S_ROOT: begin
        if (op_q == imh_pkg::OP_DECR) begin
          if (pri_lt(mv_q.pri, hr_data.pri)) begin
            if (pos_q == '0) begin
              state_d = S_FIN;
            end else begin
              hr_addr = parent;
              state_d = S_UPRD;
            end
          end else begin
            out_d = pack_out('0, '0, 1'b0, imh_pkg::ST_OK, cnt_q);
            state_d = S_OUT;
          end
        end else begin
          // extract: report root, drop its id, fetch last
          out_d = pack_out(hr_data.id, hr_data.pri, 1'b1, imh_pkg::ST_OK,
                           cnt_q - 1'b1);
          preq.we     = 1'b1;
          preq.waddr  = hr_data.id;
          preq.wvalid = 1'b0;
          cnt_d       = cnt_q - 1'b1;
          hr_addr     = cnt_d[SlotW-1:0];
          if (cnt_d == '0) begin
            state_d = S_OUT;
          end else begin
            state_d = S_LAST;
          end
        end
      end
      S_LAST: begin
        mv_d    = hr_data;
        pos_d   = '0;
        if (cnt_q > CountW'(1)) begin
          hr_addr = SlotW'(1);
          state_d = S_DNL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_UPRD: begin
        if (pri_lt(mv_q.pri, hr_data.pri)) begin
          hw_we       = 1'b1;
          hw_addr     = pos_q;
          hw_data     = hr_data;
          preq.we     = 1'b1;
          preq.waddr  = hr_data.id;
          preq.wvalid = 1'b1;
          preq.wslot  = pos_q;
          pos_d       = parent;
          if (parent == '0) begin
            state_d = S_FIN;
          end else begin
            hr_addr = (parent - 1'b1) >> 1;
            state_d = S_UPRD;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_DNL: begin
        lc_d = hr_data;
        if ({1'b0, lchild_w} + 1'b1 < {1'b0, cnt_q}) begin
          hr_addr = lchild + 1'b1;
          state_d = S_DNR;
        end else if (pri_lt(hr_data.pri, mv_q.pri)) begin
          hw_we       = 1'b1;
          hw_data     = hr_data;
          preq.we     = 1'b1;
          preq.waddr  = hr_data.id;
          preq.wvalid = 1'b1;
          preq.wslot  = pos_q;
          pos_d       = lchild;
          state_d     = S_FIN;  // left-only child is the deepest level
        end else begin
          state_d = S_FIN;
        end
      end
      S_DNR: begin
        logic             pick_r;
        imh_pkg::entry_t  c;
        logic [SlotW-1:0] cs;
        logic [CountW:0]  nl;
        pick_r = pri_lt(hr_data.pri, lc_q.pri);
        c  = pick_r ? hr_data : lc_q;
        cs = pick_r ? lchild + 1'b1 : lchild;
        nl = {1'b0, cs, 1'b1};
        if (pri_lt(c.pri, mv_q.pri)) begin
          hw_we       = 1'b1;
          hw_data     = c;
          preq.we     = 1'b1;
          preq.waddr  = c.id;
          preq.wvalid = 1'b1;
          preq.wslot  = pos_q;
          pos_d       = cs;
          if (nl < {1'b0, cnt_q}) begin
            hr_addr = nl[SlotW-1:0];
            state_d = S_DNL;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        hw_we       = 1'b1;
        hw_addr     = pos_q;
        hw_data     = mv_q;
        preq.we     = 1'b1;
        preq.waddr  = mv_q.id;
        preq.wvalid = 1'b1;
        preq.wslot  = pos_q;
        if (op_q != imh_pkg::OP_EXTRACT) begin
          out_d = pack_out('0, '0, 1'b1, imh_pkg::ST_OK, cnt_q);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        out_v_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    mv_q  <= mv_d;
    lc_q  <= lc_d;
    pos_q <= pos_d;
    out_q <= out_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(imh_pkg::Capacity)) else $error("count overflow");
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready) else $error("second operation taken");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !s_fire) |=> $stable(cnt_q)) else $error("count drift");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready) |=> out_v_q && $stable(out_q))
    else $error("result lost");
endmodule
`default_nettype wire
